// File: design/cbas_pkg.sv
// Package for the CAN configuration byte-access server.
// Holds the transfer structs, the register map codes and the status codes.
// No dependencies; the front, back and top files and the testbench import it.
package cbas_pkg;

    localparam int unsigned CFG_ADDR_W = 5;

    // Register indexes of the configuration port (byte address = 4 * index).
    localparam logic [2:0] REG_READ_REQ_PGN   = 3'd0;
    localparam logic [2:0] REG_WRITE_REQ_PGN  = 3'd1;
    localparam logic [2:0] REG_RESPONSE_PGN   = 3'd2;
    localparam logic [2:0] REG_RESPONSE_SRC   = 3'd3;
    localparam logic [2:0] REG_FW_MAJOR       = 3'd4;
    localparam logic [2:0] REG_FW_MINOR       = 3'd5;
    localparam logic [2:0] REG_MAX_READ_ADDR  = 3'd6;
    localparam logic [2:0] REG_MAX_WRITE_ADDR = 3'd7;

    // Response status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_GUARD = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    // Priority field of the response identifier.
    localparam logic [2:0] RESP_PRIORITY = 3'd3;

    localparam logic [9:0] MAX_ADDR_RESET = 10'h3FF;

    typedef struct packed {
        logic        frame_valid;
        logic [28:0] can_id;
        logic [7:0]  guard_in;
        logic [7:0]  addr_low;
        logic [7:0]  addr_high;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [28:0] resp_can_id;
        logic [7:0]  resp_fw_major;
        logic [7:0]  resp_fw_minor;
        logic [7:0]  resp_value;
        logic [15:0] resp_addr;
        logic [1:0]  resp_status;
        logic [31:0] read_total;
        logic [31:0] write_total;
        logic [15:0] guard_errors;
        logic [15:0] range_errors;
    } resp_t;

    typedef struct packed {
        logic [15:0] read_req_pgn;
        logic [15:0] write_req_pgn;
        logic [15:0] response_pgn;
        logic [7:0]  response_src_addr;
        logic [7:0]  fw_major;
        logic [7:0]  fw_minor;
        logic [9:0]  max_read_addr;
        logic [9:0]  max_write_addr;
    } cfg_t;

    // A classified request as it waits between the front and the back.
    typedef struct packed {
        logic        is_read;
        logic [1:0]  status;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } job_t;

endpackage

// File: design/cbas_ram.sv
// Generic single-port RAM with a registered read port.
// Read-first on a write cycle. No dependencies.
module cbas_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/cbas_front.sv
// Front part: accepts frames, classifies them and queues the requests.
// Depends on cbas_pkg.
module cbas_front
    import cbas_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = 1024,
    parameter logic [7:0]  GUARD_VALUE = 8'hA5
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t item,
    input  cfg_t cfg,
    input  logic hold,
    output logic busy,
    output logic job_valid,
    output job_t job,
    input  logic job_pop
);

    job_t       queue_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;

    logic [15:0] pgn;
    logic [15:0] addr;
    logic        hit_rd;
    logic        hit_wr;
    logic        push;
    logic        in_store;
    logic        in_limit;
    logic [9:0]  limit;
    job_t        job_in;

    assign busy      = (count_reg == 2'd2) || hold;
    assign job_valid = (count_reg != 2'd0);
    assign job       = queue_reg[rd_ptr_reg];

    assign pgn    = item.can_id[23:8];
    assign addr   = {item.addr_high, item.addr_low};
    assign hit_rd = (pgn == cfg.read_req_pgn);
    assign hit_wr = (pgn == cfg.write_req_pgn);
    assign push   = start && !busy && item.frame_valid && (hit_rd || hit_wr);

    // A frame that matches both PGNs is a read.
    assign limit    = hit_rd ? cfg.max_read_addr : cfg.max_write_addr;
    assign in_store = ({1'b0, addr} < 17'(STORE_DEPTH));
    assign in_limit = (addr <= {6'b0, limit});

    always_comb
    begin
        job_in.is_read = hit_rd;
        job_in.wdata   = item.write_data;
        job_in.addr    = addr;
        priority if (item.guard_in != GUARD_VALUE)
        begin
            job_in.status = ST_BAD_GUARD;
            job_in.addr   = 16'd0;
        end
        else if (!(in_store && in_limit))
        begin
            job_in.status = ST_RANGE;
        end
        else
        begin
            job_in.status = ST_OK;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (job_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !job_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (job_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// File: design/cbas_back.sv
// Back part: clears the byte store after reset, then carries out queued
// requests against it, keeps the counters and forms the responses.
// Depends on cbas_pkg and cbas_ram.
module cbas_back
    import cbas_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = 1024
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  job_valid,
    input  job_t  job,
    output logic  job_pop,
    output logic  clearing,
    output logic  result_valid,
    output resp_t result
);

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          out_valid_reg;
    logic [31:0]   read_cnt_reg;
    logic [31:0]   write_cnt_reg;
    logic [15:0]   guard_cnt_reg;
    logic [15:0]   range_cnt_reg;

    logic          use_ram_reg, use_ram_next;
    logic [7:0]    value_reg, value_next;
    logic [15:0]   addr_reg;
    logic [1:0]    status_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign job_pop  = job_valid && !clearing_reg;
    assign clearing = clearing_reg;

    assign ram_we    = clearing_reg || (job_pop && !job.is_read && (job.status == ST_OK));
    assign ram_addr  = clearing_reg ? clr_cnt_reg : job.addr[AW-1:0];
    assign ram_wdata = clearing_reg ? 8'd0 : job.wdata;

    cbas_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Reads that succeed take their value from the store's registered read
    // port; everything else carries its value in the stage register.
    always_comb
    begin
        use_ram_next = 1'b0;
        value_next   = 8'd0;
        priority if (job.status == ST_BAD_GUARD)
        begin
            value_next = 8'd0;
        end
        else if (job.is_read)
        begin
            use_ram_next = (job.status == ST_OK);
        end
        else
        begin
            value_next = job.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            read_cnt_reg  <= 32'd0;
            write_cnt_reg <= 32'd0;
            guard_cnt_reg <= 16'd0;
            range_cnt_reg <= 16'd0;
        end
        else
        begin
            out_valid_reg <= job_pop;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (job_pop)
            begin
                if (job.is_read)
                begin
                    read_cnt_reg <= read_cnt_reg + 32'd1;
                end
                else
                begin
                    write_cnt_reg <= write_cnt_reg + 32'd1;
                end
                if (job.status == ST_BAD_GUARD)
                begin
                    guard_cnt_reg <= guard_cnt_reg + 16'd1;
                end
                if (job.status == ST_RANGE)
                begin
                    range_cnt_reg <= range_cnt_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            use_ram_reg <= use_ram_next;
            value_reg   <= value_next;
            addr_reg    <= job.addr;
            status_reg  <= job.status;
        end
    end

    // Counters already hold their post-request values in the strobe cycle.
    assign result_valid         = out_valid_reg;
    assign result.resp_can_id   = {RESP_PRIORITY, 2'b00, cfg.response_pgn,
                                   cfg.response_src_addr};
    assign result.resp_fw_major = cfg.fw_major;
    assign result.resp_fw_minor = cfg.fw_minor;
    assign result.resp_value    = use_ram_reg ? ram_rdata : value_reg;
    assign result.resp_addr     = addr_reg;
    assign result.resp_status   = status_reg;
    assign result.read_total    = read_cnt_reg;
    assign result.write_total   = write_cnt_reg;
    assign result.guard_errors  = guard_cnt_reg;
    assign result.range_errors  = range_cnt_reg;

endmodule

// File: design/can_config_byte_access_server_unit.sv
// Top level of the CAN configuration byte-access server.
// Holds the configuration registers and joins front, back and byte store.
// Depends on cbas_pkg, cbas_front, cbas_back and cbas_ram.
//
// Usage: a received frame is offered on item with start high; the transfer
// happens at a rising edge where start is high and busy is low. Frames that
// are not valid or whose PGN matches neither request PGN are dropped at once
// and give no response. A request is checked for its guard byte and address
// range, queued, and then served against the byte store by the back part.
// Its single response appears on result while result_valid is high for
// exactly one cycle; the receiver cannot stall, so it must take it then.
// A request passes through the queue and the back part's stage registers
// before its response strobe rises. Outside the store clear the back part
// serves one request per cycle, so the sustained rate is one frame per
// cycle; busy rises only when the two-entry queue is full or the store is
// being cleared. Reset: configuration registers take their reset values
// and counters clear at once; the back part then clears the byte store one
// address per cycle, from 0 to STORE_DEPTH - 1. The APB port works
// throughout; it should be written only while no request is outstanding.
module can_config_byte_access_server_unit
    import cbas_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = 1024,
    parameter logic [7:0]  GUARD_VALUE = 8'hA5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  item,
    output logic                  result_valid,
    output resp_t                 result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t cfg_reg;
    logic cfg_we;
    logic [2:0] reg_idx;

    logic clearing;
    logic job_valid;
    job_t job;
    logic job_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_req_pgn      <= 16'd0;
            cfg_reg.write_req_pgn     <= 16'd0;
            cfg_reg.response_pgn      <= 16'd0;
            cfg_reg.response_src_addr <= 8'd0;
            cfg_reg.fw_major          <= 8'd0;
            cfg_reg.fw_minor          <= 8'd0;
            cfg_reg.max_read_addr     <= MAX_ADDR_RESET;
            cfg_reg.max_write_addr    <= MAX_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx)
                REG_READ_REQ_PGN:   cfg_reg.read_req_pgn      <= pwdata[15:0];
                REG_WRITE_REQ_PGN:  cfg_reg.write_req_pgn     <= pwdata[15:0];
                REG_RESPONSE_PGN:   cfg_reg.response_pgn      <= pwdata[15:0];
                REG_RESPONSE_SRC:   cfg_reg.response_src_addr <= pwdata[7:0];
                REG_FW_MAJOR:       cfg_reg.fw_major          <= pwdata[7:0];
                REG_FW_MINOR:       cfg_reg.fw_minor          <= pwdata[7:0];
                REG_MAX_READ_ADDR:  cfg_reg.max_read_addr     <= pwdata[9:0];
                REG_MAX_WRITE_ADDR: cfg_reg.max_write_addr    <= pwdata[9:0];
            endcase
        end
    end

    // Read data is zero-extended from each register's width.
    always_comb
    begin
        unique case (reg_idx)
            REG_READ_REQ_PGN:   prdata = {16'd0, cfg_reg.read_req_pgn};
            REG_WRITE_REQ_PGN:  prdata = {16'd0, cfg_reg.write_req_pgn};
            REG_RESPONSE_PGN:   prdata = {16'd0, cfg_reg.response_pgn};
            REG_RESPONSE_SRC:   prdata = {24'd0, cfg_reg.response_src_addr};
            REG_FW_MAJOR:       prdata = {24'd0, cfg_reg.fw_major};
            REG_FW_MINOR:       prdata = {24'd0, cfg_reg.fw_minor};
            REG_MAX_READ_ADDR:  prdata = {22'd0, cfg_reg.max_read_addr};
            REG_MAX_WRITE_ADDR: prdata = {22'd0, cfg_reg.max_write_addr};
        endcase
    end

    cbas_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .GUARD_VALUE (GUARD_VALUE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg       (cfg_reg),
        .hold      (clearing),
        .busy      (busy),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    cbas_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (job_valid),
        .job          (job),
        .job_pop      (job_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for can_config_byte_access_server_unit.
// Predicts every response from a local model of the store, counters and registers.
// Depends on cbas_pkg and the block's RTL only.
module testbench
    import cbas_pkg::*;
();

    // The block is built with its default store depth and guard byte, and
    // the local model uses the same values.
    localparam int unsigned   STORE_DEPTH  = 1024;
    localparam logic [7:0]    GUARD_BYTE   = 8'hA5;
    // The drain wait covers any response that is still in flight behind the
    // two-entry queue.
    localparam int            DRAIN_CYCLES = 8;
    // The cycle limit lies well above the slowest correct run, store clear
    // included.
    localparam int            CYCLE_LIMIT  = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    req_t                  frame_in;
    logic                  result_valid;
    resp_t                 resp_out;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Local copy of everything the block keeps: registers, byte store and
    // the four wrapping counters.
    cfg_t        model_cfg;
    logic [7:0]  store_model [0:STORE_DEPTH-1];
    logic [31:0] reads_seen;
    logic [31:0] writes_seen;
    logic [15:0] guard_errs;
    logic [15:0] range_errs;

    // Responses the block still owes, oldest first.
    resp_t       pending_responses [$];
    int          error_count = 0;
    int          cycle_count = 0;

    can_config_byte_access_server_unit #(
        .STORE_DEPTH (STORE_DEPTH),
        .GUARD_VALUE (GUARD_BYTE)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (frame_in),
        .result_valid (result_valid),
        .result       (resp_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a response that never comes, or a busy that never drops,
    // ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Works out the response to one accepted frame and updates the model.
    // Returns 1 when the frame is a request and therefore owes a response.
    function automatic bit predict_response(input req_t f);
        logic [15:0] pgn;
        logic [15:0] addr;
        logic [9:0]  limit;
        logic        is_read;
        resp_t       want;
        pgn  = f.can_id[23:8];
        addr = {f.addr_high, f.addr_low};
        if (!f.frame_valid)
            return 1'b0;
        // The read PGN wins when both PGNs are the same.
        if (pgn == model_cfg.read_req_pgn)
            is_read = 1'b1;
        else if (pgn == model_cfg.write_req_pgn)
            is_read = 1'b0;
        else
            return 1'b0;

        // Every request is counted, whether or not it later fails a check.
        if (is_read)
            reads_seen = reads_seen + 32'd1;
        else
            writes_seen = writes_seen + 32'd1;

        want               = '0;
        want.resp_can_id   = (29'(RESP_PRIORITY) << 26) | (29'(model_cfg.response_pgn) << 8)
                             | 29'(model_cfg.response_src_addr);
        want.resp_fw_major = model_cfg.fw_major;
        want.resp_fw_minor = model_cfg.fw_minor;
        limit              = is_read ? model_cfg.max_read_addr : model_cfg.max_write_addr;

        if (f.guard_in != GUARD_BYTE)
        begin
            // A bad guard reports neither value nor address.
            guard_errs       = guard_errs + 16'd1;
            want.resp_status = ST_BAD_GUARD;
        end
        else if (addr > 16'(limit) || addr >= STORE_DEPTH)
        begin
            // A rejected write still echoes its data byte; a rejected read
            // reports zero.
            range_errs       = range_errs + 16'd1;
            want.resp_status = ST_RANGE;
            want.resp_addr   = addr;
            want.resp_value  = is_read ? 8'h00 : f.write_data;
        end
        else
        begin
            if (!is_read)
                store_model[addr[9:0]] = f.write_data;
            want.resp_status = ST_OK;
            want.resp_addr   = addr;
            want.resp_value  = store_model[addr[9:0]];
        end

        want.read_total   = reads_seen;
        want.write_total  = writes_seen;
        want.guard_errors = guard_errs;
        want.range_errors = range_errs;
        pending_responses.push_back(want);
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Every response strobe is matched against the oldest expectation. The
    // receiver has no way to stall, so every strobe is a transfer.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin : take_response
            resp_t want;
            if (pending_responses.size() == 0)
            begin
                error_count++;
                $display("%0t ns: response with none expected, expected none, actual %h",
                         $time, resp_out);
            end
            else
            begin
                want = pending_responses.pop_front();
                check_field("resp_can_id", 32'(want.resp_can_id),
                            32'(resp_out.resp_can_id));
                check_field("resp_fw_major", 32'(want.resp_fw_major),
                            32'(resp_out.resp_fw_major));
                check_field("resp_fw_minor", 32'(want.resp_fw_minor),
                            32'(resp_out.resp_fw_minor));
                check_field("resp_value", 32'(want.resp_value), 32'(resp_out.resp_value));
                check_field("resp_addr", 32'(want.resp_addr), 32'(resp_out.resp_addr));
                check_field("resp_status", 32'(want.resp_status),
                            32'(resp_out.resp_status));
                check_field("read_total", want.read_total, resp_out.read_total);
                check_field("write_total", want.write_total, resp_out.write_total);
                check_field("guard_errors", 32'(want.guard_errors),
                            32'(resp_out.guard_errors));
                check_field("range_errors", 32'(want.range_errors),
                            32'(resp_out.range_errors));
            end
        end
    end

    // All stimulus tasks are entered just after a rising edge and return
    // just after one, so every drive lands as a nonblocking update at an edge.

    // One APB write: setup cycle, access cycle, then an idle cycle so that
    // back-to-back writes never touch psel twice in one step.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        // Only the low bits of each register are kept, as in the block.
        case (idx)
            REG_READ_REQ_PGN:   model_cfg.read_req_pgn      = data[15:0];
            REG_WRITE_REQ_PGN:  model_cfg.write_req_pgn     = data[15:0];
            REG_RESPONSE_PGN:   model_cfg.response_pgn      = data[15:0];
            REG_RESPONSE_SRC:   model_cfg.response_src_addr = data[7:0];
            REG_FW_MAJOR:       model_cfg.fw_major          = data[7:0];
            REG_FW_MINOR:       model_cfg.fw_minor          = data[7:0];
            REG_MAX_READ_ADDR:  model_cfg.max_read_addr     = data[9:0];
            REG_MAX_WRITE_ADDR: model_cfg.max_write_addr    = data[9:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] rd_pgn, input logic [31:0] wr_pgn,
                             input logic [31:0] rsp_pgn, input logic [31:0] src,
                             input logic [31:0] major, input logic [31:0] minor,
                             input logic [31:0] max_rd, input logic [31:0] max_wr);
        cfg_write(REG_READ_REQ_PGN, rd_pgn);
        cfg_write(REG_WRITE_REQ_PGN, wr_pgn);
        cfg_write(REG_RESPONSE_PGN, rsp_pgn);
        cfg_write(REG_RESPONSE_SRC, src);
        cfg_write(REG_FW_MAJOR, major);
        cfg_write(REG_FW_MINOR, minor);
        cfg_write(REG_MAX_READ_ADDR, max_rd);
        cfg_write(REG_MAX_WRITE_ADDR, max_wr);
    endtask

    function automatic req_t build_frame(input logic valid, input logic [28:0] id,
                                         input logic [7:0] guard, input logic [15:0] addr,
                                         input logic [7:0] data);
        req_t f;
        f.frame_valid = valid;
        f.can_id      = id;
        f.guard_in    = guard;
        f.addr_low    = addr[7:0];
        f.addr_high   = addr[15:8];
        f.write_data  = data;
        return f;
    endfunction

    // Offers one frame and waits for its transfer. start is left high so
    // that the next frame can follow at once; the callers lower it.
    task automatic send_frame(input req_t f, output bit answered);
        start    <= 1'b1;
        frame_in <= f;
        do
            @(posedge clk);
        while (busy);
        answered = predict_response(f);
    endtask

    task automatic send(input req_t f);
        bit answered;
        send_frame(f, answered);
    endtask

    // Holds off until nothing is owed, then lets any frame that owes no
    // response clear the pipeline before registers change.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Straight after reset both request PGNs are zero, so a frame with PGN
    // zero matches both and must be served as a read of the cleared store.
    task automatic test_after_reset();
        send(build_frame(1'b1, 29'h0000000, GUARD_BYTE, 16'h0000, 8'h5A));
        send(build_frame(1'b1, 29'h1F0000FF, GUARD_BYTE, 16'h03FF, 8'hFF));
        send(build_frame(1'b1, 29'h0000000, GUARD_BYTE, 16'hFFFF, 8'h00));
        wait_for_drain();
    endtask

    // Every request path with the identifiers and data at their extremes.
    task automatic test_request_paths();
        configure(32'h0000FFFF, 32'h00000000, 32'h0000FFFF, 32'h000000FF,
                  32'h000000FF, 32'h00000000, 32'h000003FF, 32'h000003FF);
        // Successful writes at both ends of the store, then read back.
        send(build_frame(1'b1, 29'h0000000, GUARD_BYTE, 16'h0000, 8'hFF));
        send(build_frame(1'b1, 29'h1F0000FF, GUARD_BYTE, 16'h03FF, 8'h00));
        send(build_frame(1'b1, 29'h1FFFFFFF, GUARD_BYTE, 16'h0000, 8'h00));
        send(build_frame(1'b1, 29'h1FFFFFFF, GUARD_BYTE, 16'h03FF, 8'hFF));
        // Bad guard bytes on both request kinds.
        send(build_frame(1'b1, 29'h1FFFFFFF, 8'h00, 16'h0001, 8'h11));
        send(build_frame(1'b1, 29'h0000000, 8'hFF, 16'h0002, 8'h22));
        send(build_frame(1'b1, 29'h00000000, 8'h5A, 16'h1234, 8'h33));
        // Addresses just past the store and at the top of the address space.
        send(build_frame(1'b1, 29'h0000000, GUARD_BYTE, 16'h0400, 8'hAA));
        send(build_frame(1'b1, 29'h0000000, GUARD_BYTE, 16'hFFFF, 8'h55));
        send(build_frame(1'b1, 29'h1FFFFFFF, GUARD_BYTE, 16'h0400, 8'h00));
        // Frames that must be dropped without a response.
        send(build_frame(1'b0, 29'h1FFFFFFF, GUARD_BYTE, 16'h0000, 8'h00));
        send(build_frame(1'b1, 29'h0123400, GUARD_BYTE, 16'h0000, 8'h00));
        send(build_frame(1'b0, 29'h0123400, 8'h00, 16'hFFFF, 8'hFF));
        wait_for_drain();
    endtask

    // Both address limits at zero: only address 0 passes the range check.
    task automatic test_address_limits();
        configure(32'h0000FFFF, 32'h00000000, 32'h00000000, 32'h00000000,
                  32'h00000000, 32'h000000FF, 32'h00000000, 32'h00000000);
        send(build_frame(1'b1, 29'h1FFFFFFF, GUARD_BYTE, 16'h0000, 8'h00));
        send(build_frame(1'b1, 29'h1FFFFFFF, GUARD_BYTE, 16'h0001, 8'h00));
        send(build_frame(1'b1, 29'h0000000, GUARD_BYTE, 16'h0000, 8'h3C));
        send(build_frame(1'b1, 29'h0000000, GUARD_BYTE, 16'h0001, 8'hC3));
        send(build_frame(1'b1, 29'h1FFFFFFF, GUARD_BYTE, 16'h0000, 8'h00));
        wait_for_drain();
    endtask

    // Random traffic until the given number of frames has been sent.
    // Most frames are requests with random content, aimed at low addresses so
    // that reads often find earlier writes, and at the limits; the rest are
    // random frames that the block mostly drops.
    task automatic run_traffic(input int requests, input int idle_pct);
        int          served;
        int          pick;
        int          near;
        logic        as_read;
        logic [15:0] pgn;
        logic [15:0] addr;
        logic [7:0]  guard;
        logic [9:0]  limit;
        req_t        f;
        served = 0;
        while (served < requests)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                as_read = 1'($urandom_range(0, 1));
                pgn     = as_read ? model_cfg.read_req_pgn : model_cfg.write_req_pgn;
                limit   = as_read ? model_cfg.max_read_addr : model_cfg.max_write_addr;
                guard   = ($urandom_range(0, 99) < 88) ? GUARD_BYTE : 8'($urandom);
                pick    = $urandom_range(0, 99);
                if (pick < 55)
                    addr = 16'($urandom_range(0, 63));
                else if (pick < 75)
                begin
                    near = int'(limit) + int'($urandom_range(0, 4)) - 2;
                    addr = (near < 0) ? 16'h0000 : 16'(near);
                end
                else if (pick < 85)
                    addr = 16'($urandom_range(1018, 1030));
                else
                    addr = 16'($urandom);
                f = build_frame(1'b1, {5'($urandom), pgn, 8'($urandom)}, guard, addr,
                                8'($urandom));
            end
            else
                f = build_frame(1'($urandom), 29'($urandom), 8'($urandom), 16'($urandom),
                                8'($urandom));
            send(f);
            served++;

            // Now and then the sender waits for every owed response.
            if ($urandom_range(0, 99) == 0)
            begin
                start <= 1'b0;
                do
                    @(posedge clk);
                while (pending_responses.size() != 0);
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
        wait_for_drain();
    endtask

    // Several register settings, each followed by a phase of random traffic
    // with its own sender idling. Register values carry random upper bits to
    // show that only the low bits count.
    task automatic test_random_traffic();
        logic [31:0] shared_pgn;

        configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  32'h000003FF, 32'h000003FF);
        run_traffic(265, 0);

        configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        run_traffic(265, 58);

        // Same PGN for both kinds: every request becomes a read.
        shared_pgn = $urandom;
        configure(shared_pgn, shared_pgn, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        run_traffic(265, 0);

        configure($urandom, $urandom, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000,
                  32'hFFFFFFFF, 32'hFFFFFC00, 32'hFFFFFFFF);
        run_traffic(265, 16);

        configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        run_traffic(265, 58);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        frame_in <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        // Model state after reset: registers at their defaults, store and
        // counters cleared.
        model_cfg                = '0;
        model_cfg.max_read_addr  = MAX_ADDR_RESET;
        model_cfg.max_write_addr = MAX_ADDR_RESET;
        for (int i = 0; i < STORE_DEPTH; i++)
            store_model[i] = 8'h00;
        reads_seen  = '0;
        writes_seen = '0;
        guard_errs  = '0;
        range_errs  = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The block clears its store after reset with busy high; the first
        // transfer simply waits for that to finish.
        test_after_reset();
        test_request_paths();
        test_address_limits();
        test_random_traffic();

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
